// File: src/assert_macros.svh
// Assertion macros used by the port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside of reset
`define C8_ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Check a property on every clock edge, reset included
`define C8_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed during or after reset");

`endif

// File: src/c8_pkg.sv
// Shared types, constants and tables of the CHIP-8 instruction core
`timescale 1ns / 1ps

package c8_pkg;

    // Sizes (screen sizes are powers of two)
    localparam int MEM_BYTES   = 4096;
    localparam int MEM_AW      = 12;
    localparam int SCREEN_W    = 64;
    localparam int SCREEN_H    = 32;
    localparam int X_AW        = $clog2(SCREEN_W);
    localparam int Y_AW        = $clog2(SCREEN_H);
    localparam int FONT_BASE   = 80;
    localparam int FONT_BYTES  = 80;
    localparam int STACK_DEPTH = 16;
    localparam int SP_W        = $clog2(STACK_DEPTH);
    localparam int NUM_REGS    = 16;

    localparam logic [15:0] PC_RESET = 16'h0200;

    // Request modes
    localparam logic [1:0] MODE_STEP  = 2'd0;
    localparam logic [1:0] MODE_LOAD  = 2'd1;
    localparam logic [1:0] MODE_PIXEL = 2'd2;
    localparam logic [1:0] MODE_REG   = 2'd3;

    // Opcode groups (top nibble)
    localparam logic [3:0] GRP_SYS  = 4'h0;
    localparam logic [3:0] GRP_JP   = 4'h1;
    localparam logic [3:0] GRP_CALL = 4'h2;
    localparam logic [3:0] GRP_SEI  = 4'h3;
    localparam logic [3:0] GRP_SNEI = 4'h4;
    localparam logic [3:0] GRP_SER  = 4'h5;
    localparam logic [3:0] GRP_LDI  = 4'h6;
    localparam logic [3:0] GRP_ADDI = 4'h7;
    localparam logic [3:0] GRP_ALU  = 4'h8;
    localparam logic [3:0] GRP_SNER = 4'h9;
    localparam logic [3:0] GRP_IDX  = 4'hA;
    localparam logic [3:0] GRP_JPV0 = 4'hB;
    localparam logic [3:0] GRP_DRW  = 4'hD;
    localparam logic [3:0] GRP_MISC = 4'hF;

    localparam logic [15:0] OPC_CLS = 16'h00E0;
    localparam logic [15:0] OPC_RET = 16'h00EE;

    // ALU sub-codes
    localparam logic [3:0] ALU_MOV  = 4'h0;
    localparam logic [3:0] ALU_OR   = 4'h1;
    localparam logic [3:0] ALU_AND  = 4'h2;
    localparam logic [3:0] ALU_XOR  = 4'h3;
    localparam logic [3:0] ALU_ADD  = 4'h4;
    localparam logic [3:0] ALU_SUB  = 4'h5;
    localparam logic [3:0] ALU_SHR  = 4'h6;
    localparam logic [3:0] ALU_SUBN = 4'h7;
    localparam logic [3:0] ALU_SHL  = 4'hE;

    // Misc sub-codes
    localparam logic [7:0] F_GETDLY = 8'h07;
    localparam logic [7:0] F_SETDLY = 8'h15;
    localparam logic [7:0] F_SETSND = 8'h18;
    localparam logic [7:0] F_ADDIDX = 8'h1E;
    localparam logic [7:0] F_FONT   = 8'h29;
    localparam logic [7:0] F_BCD    = 8'h33;
    localparam logic [7:0] F_STORE  = 8'h55;
    localparam logic [7:0] F_LOAD   = 8'h65;

    // Datapath micro-operations
    localparam logic [4:0] UOP_NOP     = 5'd0;
    localparam logic [4:0] UOP_CLEAR   = 5'd1;
    localparam logic [4:0] UOP_TAKE    = 5'd2;
    localparam logic [4:0] UOP_LOAD    = 5'd3;
    localparam logic [4:0] UOP_PIX_RD  = 5'd4;
    localparam logic [4:0] UOP_PIX_OUT = 5'd5;
    localparam logic [4:0] UOP_REG_RD  = 5'd6;
    localparam logic [4:0] UOP_REG_OUT = 5'd7;
    localparam logic [4:0] UOP_FETCH0  = 5'd8;
    localparam logic [4:0] UOP_FETCH1  = 5'd9;
    localparam logic [4:0] UOP_FETCH2  = 5'd10;
    localparam logic [4:0] UOP_RD_Y    = 5'd11;
    localparam logic [4:0] UOP_RD_0    = 5'd12;
    localparam logic [4:0] UOP_RD_END  = 5'd13;
    localparam logic [4:0] UOP_EXEC    = 5'd14;
    localparam logic [4:0] UOP_WR_F    = 5'd15;
    localparam logic [4:0] UOP_WR_X    = 5'd16;
    localparam logic [4:0] UOP_DRW_MRD = 5'd17;
    localparam logic [4:0] UOP_DRW_FRD = 5'd18;
    localparam logic [4:0] UOP_DRW_WR  = 5'd19;
    localparam logic [4:0] UOP_DRW_END = 5'd20;
    localparam logic [4:0] UOP_BCD     = 5'd21;
    localparam logic [4:0] UOP_ST_RD   = 5'd22;
    localparam logic [4:0] UOP_ST_WR   = 5'd23;
    localparam logic [4:0] UOP_LD_RD   = 5'd24;
    localparam logic [4:0] UOP_LD_WR   = 5'd25;
    localparam logic [4:0] UOP_FINISH  = 5'd26;

    typedef struct packed {
        logic [1:0]  mode;
        logic [11:0] load_address;
        logic [7:0]  load_data;
        logic [5:0]  pixel_x;
        logic [4:0]  pixel_y;
        logic [3:0]  reg_index;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  read_value;
        logic [15:0] program_counter;
        logic [15:0] executed_opcode;
        logic        sound_on;
        logic        display_changed;
    } t_out_item;

    typedef struct packed {
        logic [4:0]  uop;
        logic [11:0] cnt;
    } t_cmd;

    typedef struct packed {
        logic [15:0] op;
        logic        wr_flag;
        logic        wr_x;
        logic        rsp_busy;
    } t_status;

    localparam logic [7:0] FONT_ROM [0:FONT_BYTES-1] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    // Reset content of a memory byte: glyph inside the font window, else zero
    function automatic logic [7:0] font_byte(input logic [MEM_AW-1:0] a);
        logic [MEM_AW-1:0] off;
        off = a - MEM_AW'(FONT_BASE);
        if (a >= MEM_AW'(FONT_BASE) && a < MEM_AW'(FONT_BASE + FONT_BYTES)) begin
            return FONT_ROM[off[6:0]];
        end
        return 8'h00;
    endfunction

endpackage

// File: src/c8_if.sv
// Request and response channel interfaces of the CHIP-8 instruction core
`timescale 1ns / 1ps

interface c8_req_if;
    logic              valid;
    logic              ready;
    c8_pkg::t_in_item  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface c8_rsp_if;
    logic              valid;
    logic              ready;
    c8_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: src/c8_ctrl.sv
// Sequencing state machine of the CHIP-8 instruction core
`timescale 1ns / 1ps

module c8_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    input  logic [1:0]       i_req_mode,
    output logic             o_req_ready,
    output c8_pkg::t_cmd     o_cmd,
    input  c8_pkg::t_status  i_st
);

    localparam logic [4:0] S_CLEAR  = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_LOAD   = 5'd2;
    localparam logic [4:0] S_PIXRD  = 5'd3;
    localparam logic [4:0] S_PIXOUT = 5'd4;
    localparam logic [4:0] S_REGRD  = 5'd5;
    localparam logic [4:0] S_REGOUT = 5'd6;
    localparam logic [4:0] S_F0     = 5'd7;
    localparam logic [4:0] S_F1     = 5'd8;
    localparam logic [4:0] S_F2     = 5'd9;
    localparam logic [4:0] S_RY     = 5'd10;
    localparam logic [4:0] S_R0     = 5'd11;
    localparam logic [4:0] S_REND   = 5'd12;
    localparam logic [4:0] S_EXEC   = 5'd13;
    localparam logic [4:0] S_WRF    = 5'd14;
    localparam logic [4:0] S_WRX    = 5'd15;
    localparam logic [4:0] S_DMRD   = 5'd16;
    localparam logic [4:0] S_DFRD   = 5'd17;
    localparam logic [4:0] S_DWR    = 5'd18;
    localparam logic [4:0] S_DEND   = 5'd19;
    localparam logic [4:0] S_BCD    = 5'd20;
    localparam logic [4:0] S_STRD   = 5'd21;
    localparam logic [4:0] S_STWR   = 5'd22;
    localparam logic [4:0] S_LDRD   = 5'd23;
    localparam logic [4:0] S_LDWR   = 5'd24;
    localparam logic [4:0] S_FIN    = 5'd25;

    localparam logic [11:0] MEM_LAST = 12'(c8_pkg::MEM_BYTES - 1);

    logic [4:0]  r_state, n_state;
    logic [11:0] r_cnt, n_cnt;
    logic [4:0]  uop;
    logic [3:0]  grp, op_x, op_n;
    logic [7:0]  op_nn;

    assign grp   = i_st.op[15:12];
    assign op_x  = i_st.op[11:8];
    assign op_n  = i_st.op[3:0];
    assign op_nn = i_st.op[7:0];

    // Pick the next state and the micro-operation of this cycle
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        uop         = c8_pkg::UOP_NOP;
        o_req_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                uop   = c8_pkg::UOP_CLEAR;
                n_cnt = r_cnt + 12'd1;
                if (r_cnt == MEM_LAST) begin
                    n_state = S_IDLE;
                    n_cnt   = '0;
                end
            end
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    uop = c8_pkg::UOP_TAKE;
                    unique case (i_req_mode)
                        c8_pkg::MODE_STEP:  n_state = S_F0;
                        c8_pkg::MODE_LOAD:  n_state = S_LOAD;
                        c8_pkg::MODE_PIXEL: n_state = S_PIXRD;
                        c8_pkg::MODE_REG:   n_state = S_REGRD;
                    endcase
                end
            end
            S_LOAD: begin
                uop     = c8_pkg::UOP_LOAD;
                n_state = S_FIN;
            end
            S_PIXRD: begin
                uop     = c8_pkg::UOP_PIX_RD;
                n_state = S_PIXOUT;
            end
            S_PIXOUT: begin
                uop     = c8_pkg::UOP_PIX_OUT;
                n_state = S_FIN;
            end
            S_REGRD: begin
                uop     = c8_pkg::UOP_REG_RD;
                n_state = S_REGOUT;
            end
            S_REGOUT: begin
                uop     = c8_pkg::UOP_REG_OUT;
                n_state = S_FIN;
            end
            S_F0: begin
                uop     = c8_pkg::UOP_FETCH0;
                n_state = S_F1;
            end
            S_F1: begin
                uop     = c8_pkg::UOP_FETCH1;
                n_state = S_F2;
            end
            S_F2: begin
                uop     = c8_pkg::UOP_FETCH2;
                n_state = S_RY;
            end
            S_RY: begin
                uop     = c8_pkg::UOP_RD_Y;
                n_state = S_R0;
            end
            S_R0: begin
                uop     = c8_pkg::UOP_RD_0;
                n_state = S_REND;
            end
            S_REND: begin
                uop     = c8_pkg::UOP_RD_END;
                n_state = S_EXEC;
            end
            // Branch to the multi-step opcodes, the register writes or the finish
            S_EXEC: begin
                uop   = c8_pkg::UOP_EXEC;
                n_cnt = '0;
                if (grp == c8_pkg::GRP_DRW) begin
                    n_state = (op_n == 4'h0) ? S_DEND : S_DMRD;
                end else if (grp == c8_pkg::GRP_MISC && op_nn == c8_pkg::F_BCD) begin
                    n_state = S_BCD;
                end else if (grp == c8_pkg::GRP_MISC && op_nn == c8_pkg::F_STORE) begin
                    n_state = S_STRD;
                end else if (grp == c8_pkg::GRP_MISC && op_nn == c8_pkg::F_LOAD) begin
                    n_state = S_LDRD;
                end else if (i_st.wr_flag) begin
                    n_state = S_WRF;
                end else if (i_st.wr_x) begin
                    n_state = S_WRX;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_WRF: begin
                uop     = c8_pkg::UOP_WR_F;
                n_state = S_WRX;
            end
            S_WRX: begin
                uop     = c8_pkg::UOP_WR_X;
                n_state = S_FIN;
            end
            S_DMRD: begin
                uop     = c8_pkg::UOP_DRW_MRD;
                n_state = S_DFRD;
            end
            S_DFRD: begin
                uop     = c8_pkg::UOP_DRW_FRD;
                n_state = S_DWR;
            end
            S_DWR: begin
                uop = c8_pkg::UOP_DRW_WR;
                if (r_cnt[3:0] == op_n - 4'd1) begin
                    n_state = S_DEND;
                end else begin
                    n_cnt   = r_cnt + 12'd1;
                    n_state = S_DMRD;
                end
            end
            S_DEND: begin
                uop     = c8_pkg::UOP_DRW_END;
                n_state = S_FIN;
            end
            S_BCD: begin
                uop   = c8_pkg::UOP_BCD;
                n_cnt = r_cnt + 12'd1;
                if (r_cnt[1:0] == 2'd2) begin
                    n_state = S_FIN;
                end
            end
            S_STRD: begin
                uop     = c8_pkg::UOP_ST_RD;
                n_state = S_STWR;
            end
            S_STWR: begin
                uop = c8_pkg::UOP_ST_WR;
                if (r_cnt[3:0] == op_x) begin
                    n_state = S_FIN;
                end else begin
                    n_cnt   = r_cnt + 12'd1;
                    n_state = S_STRD;
                end
            end
            S_LDRD: begin
                uop     = c8_pkg::UOP_LD_RD;
                n_state = S_LDWR;
            end
            S_LDWR: begin
                uop = c8_pkg::UOP_LD_WR;
                if (r_cnt[3:0] == op_x) begin
                    n_state = S_FIN;
                end else begin
                    n_cnt   = r_cnt + 12'd1;
                    n_state = S_LDRD;
                end
            end
            // Hold until the response register is free
            S_FIN: begin
                if (!i_st.rsp_busy) begin
                    uop     = c8_pkg::UOP_FINISH;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_cmd.uop = uop;
    assign o_cmd.cnt = r_cnt;

endmodule

// File: src/c8_dpath.sv
// Datapath of the CHIP-8 instruction core: memories, registers, ALU, draw unit
`timescale 1ns / 1ps

module c8_dpath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  c8_pkg::t_cmd      i_cmd,
    input  c8_pkg::t_in_item  i_item,
    input  logic              i_rsp_ready,
    output c8_pkg::t_status   o_st,
    output logic              o_rsp_valid,
    output c8_pkg::t_out_item o_rsp_data
);

    localparam int W  = c8_pkg::SCREEN_W;
    localparam int H  = c8_pkg::SCREEN_H;
    localparam int AW = c8_pkg::MEM_AW;
    localparam int SW = c8_pkg::SP_W;

    // Split a byte into hundreds, tens or ones digit
    function automatic logic [7:0] bcd_digit(input logic [7:0] v, input logic [1:0] sel);
        logic [1:0] h;
        logic [7:0] hv;
        logic [6:0] rem;
        logic [3:0] t;
        logic [6:0] ones;
        h  = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
        hv = (h == 2'd2) ? 8'd200 : ((h == 2'd1) ? 8'd100 : 8'd0);
        rem = 7'(v - hv);
        t = 4'd0;
        for (int k = 1; k <= 9; k++) begin
            if (rem >= 7'(10 * k)) t = 4'(k);
        end
        ones = rem - 7'(7'(t) * 7'd10);
        case (sel)
            2'd0:    return {6'd0, h};
            2'd1:    return {4'd0, t};
            default: return {4'd0, ones[3:0]};
        endcase
    endfunction

    // Place a sprite byte on a row, wrapping at the screen width
    function automatic logic [W-1:0] sprite_mask(input logic [7:0] bits, input logic [7:0] x0);
        logic [W-1:0] m;
        logic [8:0]   pos;
        m = '0;
        for (int c = 0; c < 8; c++) begin
            pos = 9'(x0) + 9'(c);
            if (bits[7-c]) m[pos[c8_pkg::X_AW-1:0]] = 1'b1;
        end
        return m;
    endfunction

    // Request fields
    logic [1:0]  r_mode;
    logic [11:0] r_laddr;
    logic [7:0]  r_ldata;
    logic [5:0]  r_px;
    logic [4:0]  r_py;
    logic [3:0]  r_ridx;

    // Instruction working registers
    logic [15:0] r_op;
    logic [7:0]  r_vx, r_vy, r_v0, r_res, r_rv;
    logic        r_flag, r_coll;

    // Architectural state
    logic [15:0] r_pc, r_idx;
    logic [SW-1:0] r_sp;
    logic [7:0]  r_delay, r_sound;
    logic        r_dirty;
    logic [15:0] r_stack [c8_pkg::STACK_DEPTH];

    // Memories
    logic [7:0]   r_mem [c8_pkg::MEM_BYTES];
    logic [7:0]   r_mrd;
    logic [7:0]   r_vrf [c8_pkg::NUM_REGS];
    logic [c8_pkg::NUM_REGS-1:0] r_vrf_ok;
    logic [7:0]   r_vrd;
    logic [W-1:0] r_frame [H];
    logic [H-1:0] r_frame_ok;
    logic [W-1:0] r_frd;

    logic              r_rsp_valid;
    c8_pkg::t_out_item r_rsp;

    logic [3:0]  grp, op_x, op_n;
    logic [7:0]  op_nn;
    logic [11:0] op_nnn;
    logic [AW-1:0] idx_cnt;
    logic [8:0]  drow_sum;
    logic [7:0]  py_ext, px_ext;
    logic [SW-1:0] sp_inc, sp_dec;
    logic [W-1:0] dmask;

    logic [AW-1:0] mem_addr;
    logic          mem_we, mem_re;
    logic [7:0]    mem_wd;
    logic [3:0]    vrf_addr;
    logic          vrf_we, vrf_re;
    logic [7:0]    vrf_wd;
    localparam int Y_AWD = c8_pkg::Y_AW;
    logic [Y_AWD-1:0] fr_addr;
    logic          fr_we, fr_re;
    logic [W-1:0]  fr_wd;

    logic [7:0] n_res;
    logic       n_flag, wr_x, wr_flag;
    logic [7:0] delay_nx, sound_nx;
    logic [8:0] add9;

    assign grp    = r_op[15:12];
    assign op_x   = r_op[11:8];
    assign op_n   = r_op[3:0];
    assign op_nn  = r_op[7:0];
    assign op_nnn = r_op[11:0];
    assign idx_cnt  = r_idx[AW-1:0] + i_cmd.cnt[AW-1:0];
    assign drow_sum = 9'(r_vy) + 9'(i_cmd.cnt[3:0]);
    assign py_ext   = 8'(r_py);
    assign px_ext   = 8'(r_px);
    assign sp_inc = (r_sp == SW'(c8_pkg::STACK_DEPTH - 1)) ? '0 : r_sp + 1'b1;
    assign sp_dec = (r_sp == '0) ? SW'(c8_pkg::STACK_DEPTH - 1) : r_sp - 1'b1;
    assign dmask  = sprite_mask(r_mrd, r_vx);
    assign add9   = 9'(r_vx) + 9'(r_vy);

    // Decode which register writes follow execution
    always_comb begin
        wr_x    = 1'b0;
        wr_flag = 1'b0;
        unique case (grp)
            c8_pkg::GRP_LDI, c8_pkg::GRP_ADDI: wr_x = 1'b1;
            c8_pkg::GRP_ALU: begin
                wr_x    = (op_n <= c8_pkg::ALU_SUBN) || (op_n == c8_pkg::ALU_SHL);
                wr_flag = (op_n >= c8_pkg::ALU_ADD && op_n <= c8_pkg::ALU_SUBN)
                          || (op_n == c8_pkg::ALU_SHL);
            end
            c8_pkg::GRP_MISC: wr_x = (op_nn == c8_pkg::F_GETDLY);
            default: ;
        endcase
    end

    // Compute the register result and flag of one instruction
    always_comb begin
        n_res  = r_vx;
        n_flag = 1'b0;
        unique case (grp)
            c8_pkg::GRP_LDI:  n_res = op_nn;
            c8_pkg::GRP_ADDI: n_res = r_vx + op_nn;
            c8_pkg::GRP_ALU: begin
                unique case (op_n)
                    c8_pkg::ALU_MOV: n_res = r_vy;
                    c8_pkg::ALU_OR:  n_res = r_vx | r_vy;
                    c8_pkg::ALU_AND: n_res = r_vx & r_vy;
                    c8_pkg::ALU_XOR: n_res = r_vx ^ r_vy;
                    c8_pkg::ALU_ADD: begin
                        n_res  = add9[7:0];
                        n_flag = add9[8];
                    end
                    c8_pkg::ALU_SUB: begin
                        n_res  = r_vx - r_vy;
                        n_flag = (r_vx >= r_vy);
                    end
                    c8_pkg::ALU_SHR: begin
                        n_res  = {1'b0, r_vx[7:1]};
                        n_flag = r_vx[0];
                    end
                    c8_pkg::ALU_SUBN: begin
                        n_res  = r_vy - r_vx;
                        n_flag = (r_vy >= r_vx);
                    end
                    c8_pkg::ALU_SHL: begin
                        n_res  = {r_vx[6:0], 1'b0};
                        n_flag = r_vx[7];
                    end
                    default: ;
                endcase
            end
            c8_pkg::GRP_MISC: n_res = r_delay;
            default: ;
        endcase
    end

    // Route addresses and write data to the three memories
    always_comb begin
        mem_addr = idx_cnt;
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        mem_wd   = r_vrd;
        vrf_addr = i_cmd.cnt[3:0];
        vrf_we   = 1'b0;
        vrf_re   = 1'b0;
        vrf_wd   = r_mrd;
        fr_addr  = drow_sum[Y_AWD-1:0];
        fr_we    = 1'b0;
        fr_re    = 1'b0;
        fr_wd    = r_frd ^ dmask;
        unique case (i_cmd.uop)
            c8_pkg::UOP_CLEAR: begin
                mem_addr = i_cmd.cnt[AW-1:0];
                mem_we   = 1'b1;
                mem_wd   = c8_pkg::font_byte(i_cmd.cnt[AW-1:0]);
            end
            c8_pkg::UOP_LOAD: begin
                mem_addr = r_laddr;
                mem_we   = 1'b1;
                mem_wd   = r_ldata;
            end
            c8_pkg::UOP_PIX_RD: begin
                fr_addr = py_ext[Y_AWD-1:0];
                fr_re   = 1'b1;
            end
            c8_pkg::UOP_REG_RD: begin
                vrf_addr = r_ridx;
                vrf_re   = 1'b1;
            end
            c8_pkg::UOP_FETCH0: begin
                mem_addr = r_pc[AW-1:0];
                mem_re   = 1'b1;
            end
            c8_pkg::UOP_FETCH1: begin
                mem_addr = r_pc[AW-1:0] + AW'(1);
                mem_re   = 1'b1;
            end
            c8_pkg::UOP_FETCH2: begin
                vrf_addr = op_x;
                vrf_re   = 1'b1;
            end
            c8_pkg::UOP_RD_Y: begin
                vrf_addr = r_mrd[7:4];
                vrf_re   = 1'b1;
            end
            c8_pkg::UOP_RD_0: begin
                vrf_addr = 4'd0;
                vrf_re   = 1'b1;
            end
            c8_pkg::UOP_WR_F: begin
                vrf_addr = 4'hF;
                vrf_we   = 1'b1;
                vrf_wd   = {7'd0, r_flag};
            end
            c8_pkg::UOP_WR_X: begin
                vrf_addr = op_x;
                vrf_we   = 1'b1;
                vrf_wd   = r_res;
            end
            c8_pkg::UOP_DRW_MRD: mem_re = 1'b1;
            c8_pkg::UOP_DRW_FRD: fr_re  = 1'b1;
            c8_pkg::UOP_DRW_WR:  fr_we  = 1'b1;
            c8_pkg::UOP_DRW_END: begin
                vrf_addr = 4'hF;
                vrf_we   = 1'b1;
                vrf_wd   = {7'd0, r_coll};
            end
            c8_pkg::UOP_BCD: begin
                mem_we = 1'b1;
                mem_wd = bcd_digit(r_vx, i_cmd.cnt[1:0]);
            end
            c8_pkg::UOP_ST_RD: vrf_re = 1'b1;
            c8_pkg::UOP_ST_WR: mem_we = 1'b1;
            c8_pkg::UOP_LD_RD: mem_re = 1'b1;
            c8_pkg::UOP_LD_WR: vrf_we = 1'b1;
            default: ;
        endcase
    end

    // Main byte memory, single port with registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_addr] <= mem_wd;
        if (mem_re) r_mrd <= r_mem[mem_addr];
    end

    // General registers; an unwritten entry reads as zero
    always_ff @(posedge i_clk) begin
        if (vrf_we) r_vrf[vrf_addr] <= vrf_wd;
        if (vrf_re) r_vrd <= r_vrf_ok[vrf_addr] ? r_vrf[vrf_addr] : 8'h00;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vrf_ok <= '0;
        end else if (vrf_we) begin
            r_vrf_ok[vrf_addr] <= 1'b1;
        end
    end

    // Bitmap rows; a cleared row reads as zero
    always_ff @(posedge i_clk) begin
        if (fr_we) r_frame[fr_addr] <= fr_wd;
        if (fr_re) r_frd <= r_frame_ok[fr_addr] ? r_frame[fr_addr] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_ok <= '0;
        end else if (i_cmd.uop == c8_pkg::UOP_EXEC && r_op == c8_pkg::OPC_CLS) begin
            r_frame_ok <= '0;
        end else if (fr_we) begin
            r_frame_ok[fr_addr] <= 1'b1;
        end
    end

    // Timer values after a step
    assign delay_nx = (r_mode == c8_pkg::MODE_STEP && r_delay != 8'd0) ? r_delay - 8'd1 : r_delay;
    assign sound_nx = (r_mode == c8_pkg::MODE_STEP && r_sound != 8'd0) ? r_sound - 8'd1 : r_sound;

    // Architectural registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc    <= c8_pkg::PC_RESET;
            r_idx   <= '0;
            r_sp    <= '0;
            r_delay <= '0;
            r_sound <= '0;
            r_dirty <= 1'b0;
        end else begin
            unique case (i_cmd.uop)
                c8_pkg::UOP_FETCH2: r_pc <= r_pc + 16'd2;
                c8_pkg::UOP_EXEC: begin
                    unique case (grp)
                        c8_pkg::GRP_SYS: begin
                            if (r_op == c8_pkg::OPC_CLS) begin
                                r_dirty <= 1'b1;
                            end else if (r_op == c8_pkg::OPC_RET) begin
                                r_sp <= sp_dec;
                                r_pc <= r_stack[sp_dec];
                            end
                        end
                        c8_pkg::GRP_JP: r_pc <= 16'(op_nnn);
                        c8_pkg::GRP_CALL: begin
                            r_sp <= sp_inc;
                            r_pc <= 16'(op_nnn);
                        end
                        c8_pkg::GRP_SEI:  if (r_vx == op_nn) r_pc <= r_pc + 16'd2;
                        c8_pkg::GRP_SNEI: if (r_vx != op_nn) r_pc <= r_pc + 16'd2;
                        c8_pkg::GRP_SER:  if (r_vx == r_vy)  r_pc <= r_pc + 16'd2;
                        c8_pkg::GRP_SNER: if (r_vx != r_vy)  r_pc <= r_pc + 16'd2;
                        c8_pkg::GRP_IDX:  r_idx <= 16'(op_nnn);
                        c8_pkg::GRP_JPV0: r_pc <= 16'(op_nnn) + 16'(r_v0);
                        c8_pkg::GRP_DRW:  r_dirty <= 1'b1;
                        c8_pkg::GRP_MISC: begin
                            if (op_nn == c8_pkg::F_SETDLY) r_delay <= r_vx;
                            if (op_nn == c8_pkg::F_SETSND) r_sound <= r_vx;
                            if (op_nn == c8_pkg::F_ADDIDX) r_idx <= r_idx + 16'(r_vx);
                            if (op_nn == c8_pkg::F_FONT) begin
                                r_idx <= 16'(c8_pkg::FONT_BASE) + {6'd0, r_vx, 2'd0}
                                         + 16'(r_vx);
                            end
                        end
                        default: ;
                    endcase
                end
                c8_pkg::UOP_FINISH: begin
                    r_delay <= delay_nx;
                    r_sound <= sound_nx;
                end
                default: ;
            endcase
        end
    end

    // Return stack, written on call
    always_ff @(posedge i_clk) begin
        if (i_cmd.uop == c8_pkg::UOP_EXEC && grp == c8_pkg::GRP_CALL) begin
            r_stack[r_sp] <= r_pc;
        end
    end

    // Request fields and instruction working registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.uop)
            c8_pkg::UOP_TAKE: begin
                r_mode  <= i_item.mode;
                r_laddr <= i_item.load_address;
                r_ldata <= i_item.load_data;
                r_px    <= i_item.pixel_x;
                r_py    <= i_item.pixel_y;
                r_ridx  <= i_item.reg_index;
                r_op    <= '0;
                r_rv    <= '0;
            end
            c8_pkg::UOP_PIX_OUT: begin
                r_rv <= (px_ext < 8'(W) && py_ext < 8'(H))
                        ? {7'd0, r_frd[px_ext[c8_pkg::X_AW-1:0]]} : 8'h00;
            end
            c8_pkg::UOP_REG_OUT: r_rv <= r_vrd;
            c8_pkg::UOP_FETCH1:  r_op[15:8] <= r_mrd;
            c8_pkg::UOP_FETCH2:  r_op[7:0]  <= r_mrd;
            c8_pkg::UOP_RD_Y:    r_vx <= r_vrd;
            c8_pkg::UOP_RD_0:    r_vy <= r_vrd;
            c8_pkg::UOP_RD_END:  r_v0 <= r_vrd;
            c8_pkg::UOP_EXEC: begin
                r_res  <= n_res;
                r_flag <= n_flag;
                r_coll <= 1'b0;
            end
            c8_pkg::UOP_DRW_WR: r_coll <= r_coll | (|(r_frd & dmask));
            default: ;
        endcase
    end

    // Response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (i_cmd.uop == c8_pkg::UOP_FINISH) begin
            r_rsp_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.uop == c8_pkg::UOP_FINISH) begin
            r_rsp.read_value      <= r_rv;
            r_rsp.program_counter <= r_pc;
            r_rsp.executed_opcode <= r_op;
            r_rsp.sound_on        <= (sound_nx != 8'd0);
            r_rsp.display_changed <= r_dirty;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp_data  = r_rsp;

    assign o_st.op       = r_op;
    assign o_st.wr_flag  = wr_flag;
    assign o_st.wr_x     = wr_x;
    assign o_st.rsp_busy = r_rsp_valid & ~i_rsp_ready;

endmodule

// File: src/chip8_instruction_core.sv
// Top level of the CHIP-8 instruction core
//
//  channel  | dir | handshake    | payload
//  i_req    | in  | valid/ready  | mode, load_address, load_data, pixel_x, pixel_y, reg_index
//  o_rsp    | out | valid/ready  | read_value, program_counter, executed_opcode,
//           |     |              | sound_on, display_changed
//
// After reset the core sweeps its 4096-byte memory to load the font, with
// i_req.ready low. One request at a time; a draw handles its N rows one by one,
// FX33 writes its three digits in turn and FX55/FX65 move registers 0 to X one
// by one, as the single-port memory and register file demand.
// A finished response waits in its own register while the next request is taken.
`timescale 1ns / 1ps

module chip8_instruction_core (
    input logic       i_clk,
    input logic       i_rst_n,
    c8_req_if.sink    i_req,
    c8_rsp_if.source  o_rsp
);

    c8_pkg::t_cmd    cmd;
    c8_pkg::t_status st;

    // Sequencer
    c8_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_mode  (i_req.data.mode),
        .o_req_ready (i_req.ready),
        .o_cmd       (cmd),
        .i_st        (st)
    );

    // Datapath
    c8_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_item      (i_req.data),
        .i_rsp_ready (o_rsp.ready),
        .o_st        (st),
        .o_rsp_valid (o_rsp.valid),
        .o_rsp_data  (o_rsp.data)
    );

endmodule

// File: src/c8_chk.sv
// Port checker of the CHIP-8 instruction core and its bind
`timescale 1ns / 1ps
`include "assert_macros.svh"

module c8_chk (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_req_valid,
    input logic              i_req_ready,
    input logic              i_rsp_valid,
    input logic              i_rsp_ready,
    input c8_pkg::t_out_item i_rsp_data
);

    // Idle outputs right after reset, memory sweep blocks requests
    `C8_ASSERT_RST(a_rsp_idle_after_reset, i_clk, !i_rst_n |=> !i_rsp_valid)
    `C8_ASSERT_RST(a_req_blocked_after_reset, i_clk, !i_rst_n |=> !i_req_ready)

    // Only one request in flight
    `C8_ASSERT_CLK(a_one_request, i_clk, i_rst_n, (i_req_valid && i_req_ready) |=> !i_req_ready)

    // A step never carries a read value
    `C8_ASSERT_CLK(a_step_no_read, i_clk, i_rst_n, (i_rsp_valid && i_rsp_data.executed_opcode != 16'h0000) |-> (i_rsp_data.read_value == 8'h00))

    // Stalled response holds
    `C8_ASSERT_CLK(a_rsp_hold, i_clk, i_rst_n, (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_rsp_data)))

endmodule

bind chip8_instruction_core c8_chk u_c8_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_data  (o_rsp.data)
);

// File: tb/tb_chip8_instruction_core.sv
// Self-checking testbench of the CHIP-8 instruction core: random programs against a predictor
`timescale 1ns / 1ps

module tb_chip8_instruction_core;

    localparam int IN_W = $bits(c8_pkg::t_in_item);

    // Reference behavior of the core: state copy plus queue of expected responses
    class c8_scoreboard;
        logic [7:0]  mem [c8_pkg::MEM_BYTES];
        logic [7:0]  vreg [c8_pkg::NUM_REGS];
        logic [15:0] index_r;
        logic [15:0] pc;
        logic [15:0] ret_stack [c8_pkg::STACK_DEPTH];
        bit          ret_valid [c8_pkg::STACK_DEPTH];
        logic [3:0]  sp;
        logic [7:0]  delay_t;
        logic [7:0]  sound_t;
        bit          frame [c8_pkg::SCREEN_W * c8_pkg::SCREEN_H];
        bit          dirty;
        c8_pkg::t_out_item expected_rsp [$];
        int          errors;
        int          checked;

        function void clear_state();
            for (int a = 0; a < c8_pkg::MEM_BYTES; a++) mem[a] = 8'h00;
            for (int a = 0; a < c8_pkg::FONT_BYTES; a++)
                mem[c8_pkg::FONT_BASE + a] = c8_pkg::FONT_ROM[a];
            for (int r = 0; r < c8_pkg::NUM_REGS; r++) vreg[r] = 8'h00;
            for (int s = 0; s < c8_pkg::STACK_DEPTH; s++) begin
                ret_stack[s] = 16'h0000;
                ret_valid[s] = 0;
            end
            for (int p = 0; p < c8_pkg::SCREEN_W * c8_pkg::SCREEN_H; p++) frame[p] = 0;
            index_r = 16'h0000;
            pc      = c8_pkg::PC_RESET;
            sp      = 4'd0;
            delay_t = 8'h00;
            sound_t = 8'h00;
            dirty   = 0;
            errors  = 0;
            checked = 0;
        endfunction

        function logic [7:0] rd(input logic [15:0] a);
            return mem[a[11:0]];
        endfunction

        function logic [15:0] next_opcode();
            return {rd(pc), rd(pc + 16'd1)};
        endfunction

        // A return whose stack slot was never written must not be issued
        function bit return_unsafe();
            logic [3:0] slot;
            slot = sp - 4'd1;
            return next_opcode() == c8_pkg::OPC_RET && !ret_valid[slot];
        endfunction

        function void draw_sprite(input logic [7:0] x0, input logic [7:0] y0,
                                  input logic [3:0] rows);
            logic [7:0] bits;
            int px;
            int py;
            vreg[15] = 8'h00;
            for (int r = 0; r < rows; r++) begin
                bits = rd(index_r + 16'(r));
                for (int c = 0; c < 8; c++) begin
                    if (bits[7 - c]) begin
                        px = (x0 + c) % c8_pkg::SCREEN_W;
                        py = (y0 + r) % c8_pkg::SCREEN_H;
                        if (frame[py * c8_pkg::SCREEN_W + px]) vreg[15] = 8'h01;
                        frame[py * c8_pkg::SCREEN_W + px] ^= 1;
                    end
                end
            end
            dirty = 1;
        endfunction

        function void execute(input logic [15:0] op);
            logic [3:0] x;
            logic [3:0] y;
            logic [7:0] nn;
            logic [7:0] a;
            logic [7:0] b;
            logic [8:0] sum;
            x  = op[11:8];
            y  = op[7:4];
            nn = op[7:0];
            a  = vreg[x];
            b  = vreg[y];
            case (op[15:12])
                c8_pkg::GRP_SYS: begin
                    if (op == c8_pkg::OPC_CLS) begin
                        for (int p = 0; p < c8_pkg::SCREEN_W * c8_pkg::SCREEN_H; p++)
                            frame[p] = 0;
                        dirty = 1;
                    end else if (op == c8_pkg::OPC_RET) begin
                        sp = sp - 4'd1;
                        pc = ret_stack[sp];
                    end
                end
                c8_pkg::GRP_JP: pc = {4'h0, op[11:0]};
                c8_pkg::GRP_CALL: begin
                    ret_stack[sp] = pc;
                    ret_valid[sp] = 1;
                    sp = sp + 4'd1;
                    pc = {4'h0, op[11:0]};
                end
                c8_pkg::GRP_SEI:  if (a == nn) pc = pc + 16'd2;
                c8_pkg::GRP_SNEI: if (a != nn) pc = pc + 16'd2;
                c8_pkg::GRP_SER:  if (a == b) pc = pc + 16'd2;
                c8_pkg::GRP_LDI:  vreg[x] = nn;
                c8_pkg::GRP_ADDI: vreg[x] = a + nn;
                c8_pkg::GRP_ALU: begin
                    case (op[3:0])
                        c8_pkg::ALU_MOV: vreg[x] = b;
                        c8_pkg::ALU_OR:  vreg[x] = a | b;
                        c8_pkg::ALU_AND: vreg[x] = a & b;
                        c8_pkg::ALU_XOR: vreg[x] = a ^ b;
                        c8_pkg::ALU_ADD: begin
                            sum = {1'b0, a} + {1'b0, b};
                            vreg[15] = {7'd0, sum[8]};
                            vreg[x] = sum[7:0];
                        end
                        c8_pkg::ALU_SUB: begin
                            vreg[15] = (a >= b) ? 8'd1 : 8'd0;
                            vreg[x] = a - b;
                        end
                        c8_pkg::ALU_SHR: begin
                            vreg[15] = {7'd0, a[0]};
                            vreg[x] = a >> 1;
                        end
                        c8_pkg::ALU_SUBN: begin
                            vreg[15] = (b >= a) ? 8'd1 : 8'd0;
                            vreg[x] = b - a;
                        end
                        c8_pkg::ALU_SHL: begin
                            vreg[15] = {7'd0, a[7]};
                            vreg[x] = a << 1;
                        end
                        default: ;
                    endcase
                end
                c8_pkg::GRP_SNER: if (a != b) pc = pc + 16'd2;
                c8_pkg::GRP_IDX:  index_r = {4'h0, op[11:0]};
                c8_pkg::GRP_JPV0: pc = {4'h0, op[11:0]} + {8'h00, vreg[0]};
                c8_pkg::GRP_DRW:  draw_sprite(a, b, op[3:0]);
                c8_pkg::GRP_MISC: begin
                    case (nn)
                        c8_pkg::F_GETDLY: vreg[x] = delay_t;
                        c8_pkg::F_SETDLY: delay_t = a;
                        c8_pkg::F_SETSND: sound_t = a;
                        c8_pkg::F_ADDIDX: index_r = index_r + {8'h00, a};
                        c8_pkg::F_FONT:
                            index_r = 16'(c8_pkg::FONT_BASE) + 16'd5 * {8'h00, a};
                        c8_pkg::F_BCD: begin
                            mem[index_r[11:0]]        = 8'(a / 8'd100);
                            mem[12'(index_r + 16'd1)] = 8'((a / 8'd10) % 8'd10);
                            mem[12'(index_r + 16'd2)] = 8'(a % 8'd10);
                        end
                        c8_pkg::F_STORE:
                            for (int i = 0; i <= x; i++)
                                mem[12'(index_r + 16'(i))] = vreg[i];
                        c8_pkg::F_LOAD:
                            for (int i = 0; i <= x; i++) vreg[i] = rd(index_r + 16'(i));
                        default: ;
                    endcase
                end
                default: ;
            endcase
        endfunction

        // Apply one accepted request and queue its response
        function void note_request(input c8_pkg::t_in_item it);
            c8_pkg::t_out_item rsp;
            rsp = '0;
            case (it.mode)
                c8_pkg::MODE_STEP: begin
                    rsp.executed_opcode = next_opcode();
                    pc = pc + 16'd2;
                    execute(rsp.executed_opcode);
                    if (delay_t != 0) delay_t--;
                    if (sound_t != 0) sound_t--;
                end
                c8_pkg::MODE_LOAD:  mem[it.load_address] = it.load_data;
                c8_pkg::MODE_PIXEL:
                    rsp.read_value = {7'd0, frame[it.pixel_y * c8_pkg::SCREEN_W + it.pixel_x]};
                default:    rsp.read_value = vreg[it.reg_index];
            endcase
            rsp.program_counter = pc;
            rsp.sound_on        = (sound_t != 0);
            rsp.display_changed = dirty;
            expected_rsp.push_back(rsp);
        endfunction

        task report(input string msg);
            errors++;
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        endtask

        task check_response(input c8_pkg::t_out_item got);
            c8_pkg::t_out_item want;
            if (expected_rsp.size() == 0) begin
                report("response with no request outstanding");
                return;
            end
            want = expected_rsp.pop_front();
            checked++;
            if (got.read_value !== want.read_value)
                report($sformatf("read_value got %h want %h", got.read_value, want.read_value));
            if (got.program_counter !== want.program_counter)
                report($sformatf("program_counter got %h want %h",
                                 got.program_counter, want.program_counter));
            if (got.executed_opcode !== want.executed_opcode)
                report($sformatf("executed_opcode got %h want %h",
                                 got.executed_opcode, want.executed_opcode));
            if (got.sound_on !== want.sound_on)
                report($sformatf("sound_on got %b want %b", got.sound_on, want.sound_on));
            if (got.display_changed !== want.display_changed)
                report($sformatf("display_changed got %b want %b",
                                 got.display_changed, want.display_changed));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   no_gaps;
    int   n_steps;
    int   n_loads;
    int   n_reads;

    c8_req_if req_ch ();
    c8_rsp_if rsp_ch ();
    c8_scoreboard sb;

    chip8_instruction_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Random request with every field filled, mode forced
    function automatic c8_pkg::t_in_item rand_request(input logic [1:0] mode);
        c8_pkg::t_in_item it;
        it = c8_pkg::t_in_item'(IN_W'({$urandom, $urandom}));
        it.mode = mode;
        return it;
    endfunction

    // Pick a random instruction word, biased toward the listed opcodes
    function automatic logic [15:0] rand_opcode();
        logic [3:0]  grp;
        logic [11:0] low;
        logic [3:0]  alu_ops [10];
        logic [7:0]  misc_ops [9];
        alu_ops  = '{c8_pkg::ALU_MOV, c8_pkg::ALU_OR, c8_pkg::ALU_AND, c8_pkg::ALU_XOR,
                     c8_pkg::ALU_ADD, c8_pkg::ALU_SUB, c8_pkg::ALU_SHR, c8_pkg::ALU_SUBN,
                     c8_pkg::ALU_SHL, 4'h9};
        misc_ops = '{c8_pkg::F_GETDLY, c8_pkg::F_SETDLY, c8_pkg::F_SETSND, c8_pkg::F_ADDIDX,
                     c8_pkg::F_FONT, c8_pkg::F_BCD, c8_pkg::F_STORE, c8_pkg::F_LOAD, 8'h00};
        grp = 4'($urandom_range(0, 15));
        low = 12'($urandom);
        case (grp)
            c8_pkg::GRP_SYS: begin
                case ($urandom_range(0, 5))
                    0, 1:    return c8_pkg::OPC_CLS;
                    2, 3:    return c8_pkg::OPC_RET;
                    default: return {c8_pkg::GRP_SYS, low};
                endcase
            end
            c8_pkg::GRP_ALU:
                return {c8_pkg::GRP_ALU, low[11:4], alu_ops[$urandom_range(0, 9)]};
            c8_pkg::GRP_MISC:
                return {c8_pkg::GRP_MISC, low[11:8], misc_ops[$urandom_range(0, 8)]};
            default:  return {grp, low};
        endcase
    endfunction

    // Present one request and hold it until taken, then idle a random while
    task automatic send(input c8_pkg::t_in_item it);
        int gap;
        @(negedge i_clk);
        req_ch.valid = 1'b1;
        req_ch.data  = it;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        sb.note_request(it);
        case (it.mode)
            c8_pkg::MODE_STEP: n_steps++;
            c8_pkg::MODE_LOAD: n_loads++;
            default:   n_reads++;
        endcase
        gap = no_gaps ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            @(negedge i_clk);
            req_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic load_byte(input logic [11:0] addr, input logic [7:0] value);
        c8_pkg::t_in_item it;
        it = rand_request(c8_pkg::MODE_LOAD);
        it.load_address = addr;
        it.load_data    = value;
        send(it);
    endtask

    task automatic load_word(input logic [11:0] addr, input logic [15:0] word);
        load_byte(addr, word[15:8]);
        load_byte(addr + 12'd1, word[7:0]);
    endtask

    // Execute one instruction; patch a return that would pop an unwritten slot
    task automatic step();
        if (sb.return_unsafe())
            load_word(sb.pc[11:0], {c8_pkg::GRP_LDI, 12'($urandom)});
        send(rand_request(c8_pkg::MODE_STEP));
    endtask

    task automatic read_pixel(input logic [5:0] x, input logic [4:0] y);
        c8_pkg::t_in_item it;
        it = rand_request(c8_pkg::MODE_PIXEL);
        it.pixel_x = x;
        it.pixel_y = y;
        send(it);
    endtask

    task automatic read_reg(input logic [3:0] r);
        c8_pkg::t_in_item it;
        it = rand_request(c8_pkg::MODE_REG);
        it.reg_index = r;
        send(it);
    endtask

    // Hold off the sender until every response is back
    task automatic drain();
        @(negedge i_clk);
        req_ch.valid = 1'b0;
        while (sb.expected_rsp.size() != 0) @(posedge i_clk);
    endtask

    // Response side: random stall before each response
    initial begin
        int stall;
        rsp_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, 9);
            repeat (stall) begin
                @(negedge i_clk);
                rsp_ch.ready = 1'b0;
            end
            @(negedge i_clk);
            rsp_ch.ready = 1'b1;
            @(posedge i_clk);
            while (!rsp_ch.valid) @(posedge i_clk);
        end
    end

    // Check every accepted response
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) sb.check_response(rsp_ch.data);
    end

    // Main sequence
    initial begin
        int n_instr;
        logic [15:0] directed_prog [6];
        sb = new();
        sb.clear_state();
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        no_gaps = 0;
        n_steps = 0;
        n_loads = 0;
        n_reads = 0;
        i_rst_n = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: field extremes, carry add, clear and a font sprite draw
        read_reg(4'd0);
        read_reg(4'd15);
        read_pixel(6'd0, 5'd0);
        read_pixel(6'd63, 5'd31);
        load_byte(12'hFFF, 8'hFF);
        load_byte(12'h000, 8'h00);
        directed_prog = '{c8_pkg::OPC_CLS, {c8_pkg::GRP_LDI, 12'h0FF},
                          {c8_pkg::GRP_LDI, 12'h101}, {c8_pkg::GRP_ALU, 8'h01, c8_pkg::ALU_ADD},
                          {c8_pkg::GRP_IDX, 12'h050}, {c8_pkg::GRP_DRW, 12'h015}};
        for (int i = 0; i < 6; i++) load_word(12'h200 + 12'(2 * i), directed_prog[i]);
        repeat (6) step();
        read_reg(4'd15);
        read_pixel(6'd1, 5'd1);

        // Random: short programs written at the PC, then run, with reads mixed in
        while (n_steps + n_loads + n_reads < 1450) begin
            if ($urandom_range(0, 19) == 0) begin
                drain();
                no_gaps = ($urandom_range(0, 2) == 0);
            end
            n_instr = $urandom_range(1, 8);
            for (int i = 0; i < n_instr; i++)
                load_word(sb.pc[11:0] + 12'(2 * i), rand_opcode());
            for (int i = 0; i < n_instr; i++) begin
                step();
                case ($urandom_range(0, 5))
                    0: read_reg(4'($urandom));
                    1: read_pixel(6'($urandom), 5'($urandom));
                    default: ;
                endcase
            end
            if ($urandom_range(0, 9) == 0) load_byte(12'($urandom), 8'($urandom));
        end

        drain();
        repeat (100) @(posedge i_clk);
        $display("Covered %0d steps, %0d memory loads and %0d pixel/register reads;",
                 n_steps, n_loads, n_reads);
        $display("%0d responses compared, %0d mismatches.", sb.checked, sb.errors);
        if (sb.errors == 0 && sb.expected_rsp.size() == 0) begin
            $display("chip8_instruction_core test passed");
        end else begin
            $display("chip8_instruction_core test failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("chip8_instruction_core test failed");
        $finish;
    end

endmodule
